// ===== hw/rtl/int_to_decimal_ascii_defines.svh =====
// Assertion macros for the int_to_decimal_ascii block.
// Assertions are removed when SYNTHESIS is defined.
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
`define ITDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("itda assertion failed");
`define ITDA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("itda forbidden condition");
`else
`define ITDA_ASSERT(lbl, prop)
`define ITDA_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/itda_pkg.sv =====
package itda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigW      = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW      = 4;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  // quotient by ten: floor(x * ceil(2^35 / 10) / 2^35), exact for 32-bit x
  localparam logic [ValueW-1:0] RecipMul   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  typedef struct packed {
    logic load;
    logic divide;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic quo_zero;
    logic neg;
    logic last_digit;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/itda_in_if.sv =====
interface itda_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [itda_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/itda_out_if.sv =====
interface itda_out_if;
  logic                       valid;
  logic                       ready;
  logic [itda_pkg::CharW-1:0] char_code;
  logic                       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== hw/rtl/itda_ctrl.sv =====
module itda_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  itda_pkg::sts_t  sts_i,
  output itda_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.divide = 1'b1;
        if (sts_i.quo_zero) begin
          state_d = sts_i.neg ? StSign : StEmit;
        end
      end
      StSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/itda_dpath.sv =====
`include "int_to_decimal_ascii_defines.svh"

module itda_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [itda_pkg::ValueW-1:0] value_i,
  input  itda_pkg::cmd_t                    cmd_i,
  output itda_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [itda_pkg::CharW-1:0]        out_char_o,
  output logic                              out_last_o
);

  logic [itda_pkg::ValueW-1:0] mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic [itda_pkg::MaxDigits-1:0][itda_pkg::DigW-1:0] stk_q, stk_d;
  logic [itda_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [itda_pkg::CharW-1:0]  out_char_q, out_char_d;
  logic                        out_last_q, out_last_d;

  logic [2*itda_pkg::ValueW-1:0] prod;
  logic [itda_pkg::ValueW-1:0]   quo;
  logic [itda_pkg::ValueW-1:0]   quo10;
  logic [itda_pkg::ValueW-1:0]   rem_full;
  logic [itda_pkg::DigW-1:0]     rem;
  logic                          out_free;

  // divide by ten through the reciprocal
  assign prod     = {{itda_pkg::ValueW{1'b0}}, mag_q}
                  * {{itda_pkg::ValueW{1'b0}}, itda_pkg::RecipMul};
  assign quo      = itda_pkg::ValueW'(prod >> itda_pkg::RecipShift);
  assign quo10    = (quo << 3) + (quo << 1);
  assign rem_full = mag_q - quo10;
  assign rem      = rem_full[itda_pkg::DigW-1:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    stk_d       = stk_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (cmd_i.load) begin
      neg_d = value_i[itda_pkg::ValueW-1];
      mag_d = value_i[itda_pkg::ValueW-1] ? (~value_i + 1'b1) : value_i;
      cnt_d = '0;
    end
    if (cmd_i.divide) begin
      mag_d = quo;
      stk_d = {stk_q[itda_pkg::MaxDigits-2:0], rem};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = itda_pkg::CharMinus;
      out_last_d  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = itda_pkg::CharZero + {{(itda_pkg::CharW-itda_pkg::DigW){1'b0}}, stk_q[0]};
      out_last_d  = (cnt_q == itda_pkg::CntW'(1));
      stk_d       = {{itda_pkg::DigW{1'b0}}, stk_q[itda_pkg::MaxDigits-1:1]};
      cnt_d       = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    stk_q      <= stk_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.quo_zero   = (quo == '0);
  assign sts_o.neg        = neg_q;
  assign sts_o.last_digit = (cnt_q == itda_pkg::CntW'(1));
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  `ITDA_ASSERT(a_cnt_bound, cnt_q <= itda_pkg::CntW'(itda_pkg::MaxDigits))
  `ITDA_ASSERT(a_emit_nonempty, cmd_i.emit_digit |-> cnt_q != '0)
  `ITDA_ASSERT(a_char_legal, out_valid_q |-> (out_char_q == itda_pkg::CharMinus ||
    (out_char_q >= itda_pkg::CharZero && out_char_q <= itda_pkg::CharNine)))
  `ITDA_ASSERT_NEVER(a_one_emit, cmd_i.emit_sign && cmd_i.emit_digit)

endmodule

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// Channel | Dir | Payload                 | Handshake
// in_i    | in  | value (32b signed)      | valid/ready, transfer when both high
// out_o   | out | char_code (8b), last    | valid/ready, transfer when both high
//
// One number at a time: a load, one divide-by-ten step per digit
// (reciprocal multiplier), then one emit step per character ('-' and digits).
// Output sits in a register, so a new number is taken while the last char waits.
// Output stalls hold the emit sequence; asynchronous active-low reset idles.
module int_to_decimal_ascii (
  input  logic              clk_i,
  input  logic              rst_ni,
  itda_in_if.sink           in_i,
  itda_out_if.source        out_o
);

  itda_pkg::cmd_t cmd;
  itda_pkg::sts_t sts;

  itda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itda_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.char_code),
    .out_last_o  (out_o.last)
  );

endmodule
